@@ rtl/itp_pkg.sv @@
// ----------------------------------------------------------------------------
// itp_pkg: shared types and constants of the timestamp parser
// Character codes, parse phases, controller/datapath command and status
// structs, and the fixed-point constants of the epoch conversion.
// ----------------------------------------------------------------------------
package itp_pkg;

  // Character codes
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_T_UC  = 8'h54;
  localparam logic [7:0] CH_T_LC  = 8'h74;
  localparam logic [7:0] CH_Z_UC  = 8'h5A;
  localparam logic [7:0] CH_Z_LC  = 8'h7A;

  // Date field layout: YYYY-MM-DD
  localparam logic [3:0] YEAR_END   = 4'd4;
  localparam logic [3:0] MONTH_END  = 4'd7;
  localparam logic [3:0] DATE_LEN   = 4'd10;

  // Epoch conversion constants
  localparam int HOUR_SECONDS   = 3600;
  localparam int MINUTE_SECONDS = 60;
  localparam int DAY_SECONDS    = 86400;
  localparam int YEAR_DAYS      = 365;
  // civil year shifted to a March-based year, plus 400 to stay positive
  localparam int YEAR_BIAS      = 399;
  // one era (146097) plus days from 0000-03-01 to 1970-01-01, plus one
  localparam int DAY_BIAS       = 865566;
  // x / 12 = (x * 171) >> 11 for x below 128
  localparam int DIV12_MUL      = 171;
  localparam int DIV12_SHIFT    = 11;
  // x / 25 = (x * 2622) >> 16 for x below 2700
  localparam int DIV25_MUL      = 2622;
  localparam int DIV25_SHIFT    = 16;

  // Cycles from the last character to the loaded result
  localparam int CALC_CYCLES    = 5;
  localparam int CALC_W         = $clog2(CALC_CYCLES);

  typedef enum logic [18:0] {
    PH_DATE   = 19'b000_0000_0000_0000_0001,
    PH_SEP    = 19'b000_0000_0000_0000_0010,
    PH_H1     = 19'b000_0000_0000_0000_0100,
    PH_H2     = 19'b000_0000_0000_0000_1000,
    PH_AFT_H  = 19'b000_0000_0000_0001_0000,
    PH_MI1    = 19'b000_0000_0000_0010_0000,
    PH_MI2    = 19'b000_0000_0000_0100_0000,
    PH_AFT_M  = 19'b000_0000_0000_1000_0000,
    PH_S1     = 19'b000_0000_0001_0000_0000,
    PH_S2     = 19'b000_0000_0010_0000_0000,
    PH_AFT_S  = 19'b000_0000_0100_0000_0000,
    PH_FRAC   = 19'b000_0000_1000_0000_0000,
    PH_OH1    = 19'b000_0001_0000_0000_0000,
    PH_OH2    = 19'b000_0010_0000_0000_0000,
    PH_AFT_OH = 19'b000_0100_0000_0000_0000,
    PH_OM1    = 19'b000_1000_0000_0000_0000,
    PH_OM2    = 19'b001_0000_0000_0000_0000,
    PH_OMN    = 19'b010_0000_0000_0000_0000,
    PH_DONE   = 19'b100_0000_0000_0000_0000
  } phase_t;

  typedef enum logic [2:0] {
    MODE_PARSE = 3'b001,
    MODE_CALC  = 3'b010,
    MODE_SEND  = 3'b100
  } mode_t;

  typedef enum logic [2:0] {
    FLD_NONE,
    FLD_HOUR,
    FLD_MIN,
    FLD_SEC,
    FLD_ZH,
    FLD_ZM
  } field_t;

  typedef struct packed {
    logic   date_step;  // run one date character
    field_t push;       // append the digit to a time or zone field
    logic   zm_first;   // load zone minutes with the digit
    logic   zm_clear;   // zero zone minutes
    logic   zone_set;   // mark a zone as present
    logic   sign_set;   // capture the offset sign
    logic   load_out;   // load the result register
    logic   bad;        // result is an error
    logic   clear;      // return fields to reset values
  } cmd_t;

  typedef struct packed {
    logic digit;
    logic colon;
    logic dot;
    logic sep;
    logic zletter;
    logic plus;
    logic minus;
    logic date_err;
    logic date_last;
  } stat_t;

  // Day of the March-based year at which month mp (0 = March) starts
  function automatic logic [8:0] doy_of(input logic [3:0] mp);
    logic [8:0] d;
    unique case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

@@ rtl/itp_ctrl.sv @@
// ----------------------------------------------------------------------------
// itp_ctrl: parse and sequencing controller
// Walks the grammar one character per request, issues field commands to the
// datapath, then times the conversion and holds the result handshake.
// ----------------------------------------------------------------------------
module itp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          last,
  input  logic          out_ready,
  input  itp_pkg::stat_t stat,
  output logic          in_ready,
  output logic          out_valid,
  output itp_pkg::cmd_t cmd
);
  import itp_pkg::*;

  localparam logic [CALC_W-1:0] CALC_LAST = CALC_W'(CALC_CYCLES - 1);

  phase_t            phase;
  phase_t            phase_next;
  mode_t             mode;
  logic              err;
  logic              err_next;
  logic              bad_q;
  logic              fin_bad;
  logic [CALC_W-1:0] calc_cnt;
  logic              accept;
  logic              zone_try;
  cmd_t              pcmd;

  assign in_ready  = (mode == MODE_PARSE);
  assign out_valid = (mode == MODE_SEND);
  assign accept    = in_valid && in_ready;

  // Next phase and field commands for the current character
  always_comb begin
    phase_next = phase;
    err_next   = err;
    zone_try   = 1'b0;
    pcmd       = '0;
    pcmd.push  = FLD_NONE;
    unique case (phase)
      PH_DATE: begin
        pcmd.date_step = 1'b1;
        if (stat.date_err) err_next = 1'b1;
        if (stat.date_last) phase_next = PH_SEP;
      end
      PH_SEP:   phase_next = stat.sep ? PH_H1 : PH_DONE;
      PH_H1, PH_H2: begin
        if (!stat.digit) begin
          err_next   = 1'b1;
          phase_next = PH_DONE;
        end else begin
          pcmd.push  = FLD_HOUR;
          phase_next = (phase == PH_H1) ? PH_H2 : PH_AFT_H;
        end
      end
      PH_AFT_H: begin
        if (stat.colon) phase_next = PH_MI1;
        else if (stat.dot) phase_next = PH_FRAC;
        else zone_try = 1'b1;
      end
      PH_MI1, PH_MI2: begin
        if (!stat.digit) begin
          err_next   = 1'b1;
          phase_next = PH_DONE;
        end else begin
          pcmd.push  = FLD_MIN;
          phase_next = (phase == PH_MI1) ? PH_MI2 : PH_AFT_M;
        end
      end
      PH_AFT_M: begin
        if (stat.colon) phase_next = PH_S1;
        else if (stat.dot) phase_next = PH_FRAC;
        else zone_try = 1'b1;
      end
      PH_S1, PH_S2: begin
        if (!stat.digit) begin
          err_next   = 1'b1;
          phase_next = PH_DONE;
        end else begin
          pcmd.push  = FLD_SEC;
          phase_next = (phase == PH_S1) ? PH_S2 : PH_AFT_S;
        end
      end
      PH_AFT_S: begin
        if (stat.dot) phase_next = PH_FRAC;
        else zone_try = 1'b1;
      end
      PH_FRAC: begin
        if (!stat.digit) zone_try = 1'b1;
      end
      PH_OH1, PH_OH2: begin
        if (!stat.digit) begin
          err_next   = 1'b1;
          phase_next = PH_DONE;
        end else begin
          pcmd.push  = FLD_ZH;
          phase_next = (phase == PH_OH1) ? PH_OH2 : PH_AFT_OH;
        end
      end
      PH_AFT_OH: begin
        if (stat.colon) begin
          phase_next = PH_OM1;
        end else if (stat.digit) begin
          pcmd.zm_first = 1'b1;
          phase_next    = PH_OMN;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_OM1, PH_OM2: begin
        if (!stat.digit) begin
          err_next   = 1'b1;
          phase_next = PH_DONE;
        end else begin
          pcmd.push  = FLD_ZM;
          phase_next = (phase == PH_OM1) ? PH_OM2 : PH_DONE;
        end
      end
      PH_OMN: begin
        if (stat.digit) pcmd.push = FLD_ZM;
        else pcmd.zm_clear = 1'b1;
        phase_next = PH_DONE;
      end
      PH_DONE: ;
      default: phase_next = PH_DONE;
    endcase

    // Zone letter, signed offset, or end of the recognized text
    if (zone_try) begin
      pcmd.zone_set = stat.zletter || stat.plus || stat.minus;
      pcmd.sign_set = stat.plus || stat.minus;
      phase_next    = (stat.plus || stat.minus) ? PH_OH1 : PH_DONE;
    end

    // A lone offset-minute digit at the end counts as zero minutes
    if (last && (phase_next == PH_OMN)) pcmd.zm_clear = 1'b1;
  end

  // An error was seen, or the text ended short of the date or inside a required digit pair
  assign fin_bad = err_next || (phase_next == PH_DATE)
                || (phase_next == PH_H1)  || (phase_next == PH_H2)
                || (phase_next == PH_MI1) || (phase_next == PH_MI2)
                || (phase_next == PH_S1)  || (phase_next == PH_S2)
                || (phase_next == PH_OH1) || (phase_next == PH_OH2)
                || (phase_next == PH_OM1) || (phase_next == PH_OM2);

  always_comb begin
    cmd          = accept ? pcmd : '0;
    if (!accept) cmd.push = FLD_NONE;
    cmd.load_out = (mode == MODE_CALC) && (calc_cnt == CALC_LAST);
    cmd.bad      = bad_q;
    cmd.clear    = (mode == MODE_SEND) && out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_DATE;
      mode     <= MODE_PARSE;
      err      <= 1'b0;
      bad_q    <= 1'b0;
      calc_cnt <= '0;
    end else begin
      unique case (mode)
        MODE_PARSE: begin
          if (accept) begin
            phase <= phase_next;
            err   <= err_next;
            if (last) begin
              mode     <= MODE_CALC;
              bad_q    <= fin_bad;
              calc_cnt <= '0;
            end
          end
        end
        MODE_CALC: begin
          calc_cnt <= calc_cnt + 1'b1;
          if (calc_cnt == CALC_LAST) mode <= MODE_SEND;
        end
        MODE_SEND: begin
          if (out_ready) begin
            mode  <= MODE_PARSE;
            phase <= PH_DATE;
            err   <= 1'b0;
          end
        end
        default: mode <= MODE_PARSE;
      endcase
    end
  end

endmodule

@@ rtl/itp_datapath.sv @@
// ----------------------------------------------------------------------------
// itp_datapath: field registers and epoch conversion pipeline
// Classifies characters, accumulates date, time and zone fields, and turns
// them into UTC seconds through a four-stage pipeline and a result register.
// ----------------------------------------------------------------------------
module itp_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          char_code,
  input  itp_pkg::cmd_t       cmd,
  output itp_pkg::stat_t      stat,
  output logic                status,
  output logic signed [38:0]  epoch_seconds,
  output logic                zone_given
);
  import itp_pkg::*;

  function automatic logic [6:0] push2(input logic [6:0] acc, input logic [3:0] d);
    return 7'(acc * 7'd10 + {3'b000, d});
  endfunction

  // Fields
  logic [3:0]  char_count;
  logic [13:0] year_value;
  logic [6:0]  month_value;
  logic [6:0]  day_value;
  logic [6:0]  hour_value;
  logic [6:0]  minute_value;
  logic [6:0]  second_value;
  logic        zone_negative;
  logic [6:0]  zone_hours;
  logic [6:0]  zone_minutes;
  logic        zone_seen;

  logic        digit;
  logic [3:0]  dval;
  logic        dash_pos;

  // Stage 1 logic and registers
  logic [7:0]  mm;
  logic [15:0] q12_prod;
  logic [3:0]  q12;
  logic [7:0]  r12_full;
  logic [3:0]  r12;
  logic        early;
  logic [3:0]  mp;
  logic [13:0] s1_y;
  logic [8:0]  s1_doy;
  logic [18:0] s1_tsec;
  logic [18:0] s1_zsec;

  // Stage 2
  logic [11:0] ysh;
  logic [23:0] q100_prod;
  logic signed [20:0] t_s;
  logic signed [20:0] z_s;
  logic [6:0]  s2_q100;
  logic [21:0] s2_dsum;
  logic signed [20:0] s2_tod;

  // Stage 3 and 4
  logic signed [23:0] s3_days;
  logic signed [20:0] s3_tod;
  logic signed [41:0] s4_prod;
  logic signed [20:0] s4_tod;
  logic signed [41:0] sum;

  assign digit    = (char_code >= CH_0) && (char_code <= CH_9);
  assign dval     = 4'(char_code - CH_0);
  assign dash_pos = (char_count == YEAR_END) || (char_count == MONTH_END);

  always_comb begin
    stat.digit     = digit;
    stat.colon     = (char_code == CH_COLON);
    stat.dot       = (char_code == CH_DOT);
    stat.sep       = (char_code == CH_T_UC) || (char_code == CH_T_LC)
                  || (char_code == CH_SPACE);
    stat.zletter   = (char_code == CH_Z_UC) || (char_code == CH_Z_LC);
    stat.plus      = (char_code == CH_PLUS);
    stat.minus     = (char_code == CH_DASH);
    stat.date_err  = dash_pos ? (char_code != CH_DASH) : !digit;
    stat.date_last = (char_count == DATE_LEN - 4'd1);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      char_count    <= '0;
      year_value    <= '0;
      month_value   <= '0;
      day_value     <= '0;
      hour_value    <= '0;
      minute_value  <= '0;
      second_value  <= '0;
      zone_negative <= 1'b0;
      zone_hours    <= '0;
      zone_minutes  <= '0;
      zone_seen     <= 1'b0;
    end else begin
      if (cmd.date_step) begin
        if (!dash_pos && digit) begin
          if (char_count < YEAR_END) begin
            year_value <= 14'(year_value * 14'd10 + {10'd0, dval});
          end else if (char_count < MONTH_END) begin
            month_value <= push2(month_value, dval);
          end else begin
            day_value <= push2(day_value, dval);
          end
        end
        if (char_count != DATE_LEN) char_count <= char_count + 4'd1;
      end
      unique case (cmd.push)
        FLD_HOUR: hour_value   <= push2(hour_value, dval);
        FLD_MIN:  minute_value <= push2(minute_value, dval);
        FLD_SEC:  second_value <= push2(second_value, dval);
        FLD_ZH:   zone_hours   <= push2(zone_hours, dval);
        FLD_NONE, FLD_ZM: ;
        default: ;
      endcase
      // clear wins over a digit that arrives on the final character
      if (cmd.zm_clear) zone_minutes <= '0;
      else if (cmd.zm_first) zone_minutes <= {3'b000, dval};
      else if (cmd.push == FLD_ZM) zone_minutes <= push2(zone_minutes, dval);
      if (cmd.zone_set) zone_seen <= 1'b1;
      if (cmd.sign_set) zone_negative <= stat.minus;
    end
  end

  // Stage 1: March-based year and month, time of day, zone offset
  always_comb begin
    mm       = {1'b0, month_value} + 8'd11;
    q12_prod = {8'd0, mm} * 16'(DIV12_MUL);
    q12      = 4'(q12_prod >> DIV12_SHIFT);
    r12_full = mm - {4'd0, q12} * 8'd12;
    r12      = r12_full[3:0];
    early    = (r12 <= 4'd1);
    mp       = early ? r12 + 4'd10 : r12 - 4'd2;
  end

  always_ff @(posedge clk) begin
    s1_y    <= year_value + 14'(YEAR_BIAS) + {10'd0, q12} - {13'd0, early};
    s1_doy  <= doy_of(mp);
    s1_tsec <= 19'(hour_value) * 19'(HOUR_SECONDS)
             + 19'(minute_value) * 19'(MINUTE_SECONDS) + 19'(second_value);
    s1_zsec <= 19'(zone_hours) * 19'(HOUR_SECONDS)
             + 19'(zone_minutes) * 19'(MINUTE_SECONDS);
  end

  // Stage 2: century count, day sum, offset applied
  assign ysh       = s1_y[13:2];
  assign q100_prod = {12'd0, ysh} * 24'(DIV25_MUL);
  assign t_s       = $signed({2'b00, s1_tsec});
  assign z_s       = $signed({2'b00, s1_zsec});

  always_ff @(posedge clk) begin
    s2_q100 <= 7'(q100_prod >> DIV25_SHIFT);
    s2_dsum <= 22'(s1_y) * 22'(YEAR_DAYS) + {10'd0, ysh} + {13'd0, s1_doy}
             + {15'd0, day_value};
    s2_tod  <= zone_negative ? t_s + z_s : t_s - z_s;
  end

  // Stage 3: days since the epoch
  always_ff @(posedge clk) begin
    s3_days <= $signed({2'b00, s2_dsum}) - $signed({17'd0, s2_q100})
             + $signed({19'd0, s2_q100[6:2]}) - 24'(DAY_BIAS);
    s3_tod  <= s2_tod;
  end

  // Stage 4: days to seconds
  always_ff @(posedge clk) begin
    s4_prod <= s3_days * 18'(DAY_SECONDS);
    s4_tod  <= s3_tod;
  end

  assign sum = s4_prod + 42'(s4_tod);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status        <= cmd.bad;
      epoch_seconds <= cmd.bad ? '0 : sum[38:0];
      zone_given    <= !cmd.bad && zone_seen;
    end
  end

endmodule

@@ rtl/iso8601_timestamp_parser.sv @@
// ----------------------------------------------------------------------------
// iso8601_timestamp_parser: streaming ISO 8601 / RFC 3339 timestamp parser
// Parses a timestamp text one character per request and returns its status
// and UTC epoch seconds once the last character has been taken.
// ----------------------------------------------------------------------------
// The block takes one ASCII character per clock on the input channel while it
// parses; the character flagged last closes the text. It accepts YYYY-MM-DD,
// then optionally T, t or space with hh, :mm, :ss, a skipped fraction, and Z
// or a signed offset hh[:mm|mm]; anything after the recognized part is
// ignored. Out-of-range fields roll over as a proleptic Gregorian timegm, and
// the offset is subtracted. After the last character the input stalls while
// the four-stage conversion pipeline in the datapath runs into the result
// register; then the result request is held until taken and the next text is
// accepted from the following cycle. Status 1 marks a malformed or short
// text; epoch_seconds and zone_given are then 0.
// ----------------------------------------------------------------------------
module iso8601_timestamp_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         char_code,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               status,
  output logic signed [38:0] epoch_seconds,
  output logic               zone_given
);
  import itp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Grammar walk, conversion timing and both handshakes
  itp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last      (last),
    .out_ready (out_ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Character classes, field accumulators, conversion and result register
  itp_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .char_code     (char_code),
    .cmd           (cmd),
    .stat          (stat),
    .status        (status),
    .epoch_seconds (epoch_seconds),
    .zone_given    (zone_given)
  );

endmodule

@@ rtl/itp_checker.sv @@
// ----------------------------------------------------------------------------
// itp_checker: port-level checks for the timestamp parser
// Watches the top-level ports over time; attached to the top by bind.
// ----------------------------------------------------------------------------
module itp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [7:0]         char_code,
  input logic               last,
  input logic               out_valid,
  input logic               out_ready,
  input logic               status,
  input logic signed [38:0] epoch_seconds,
  input logic               zone_given
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status)
      && $stable(epoch_seconds) && $stable(zone_given))
    else $error("result changed while stalled");

  // An error result carries no time and no zone
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> (epoch_seconds == '0) && !zone_given)
    else $error("error result with nonzero payload");

  // Input is never taken while a result waits
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input ready while result pending");

  // The last character starts the conversion: input stalls, no result yet
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last |=> !in_ready && !out_valid)
    else $error("block did not enter conversion after last character");

endmodule

bind iso8601_timestamp_parser itp_checker u_itp_checker (.*);

@@ tb/tb_iso8601_timestamp_parser.sv @@
// ----------------------------------------------------------------------------
// tb_iso8601_timestamp_parser: self-checking bench for the timestamp parser
// Streams timestamp texts one character per request into the parser. A
// character-level model predicts status, epoch seconds and zone flag for each
// text, and every result is compared against the oldest prediction. Directed
// texts come first, then random well-formed, broken and noise texts under
// several sender and receiver idling mixes, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_iso8601_timestamp_parser;
  import itp_pkg::*;

  // Cycles with no request taken on either channel before the run is aborted.
  // The longest legal quiet stretch is the receiver hold-off below.
  localparam int QUIET_LIMIT    = 5000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_CHARS     = 280;

  typedef struct packed {
    logic               status;
    logic signed [38:0] epoch;
    logic               zone;
  } stamp_t;

  // Character-level model of the parser plus the FIFO of predicted stamps.
  class timestamp_scoreboard;
    phase_t      phase;
    logic [3:0]  date_cnt;
    logic [13:0] year_f;
    logic [6:0]  month_f, day_f, hour_f, minute_f, second_f, zone_h, zone_m;
    logic        zone_neg, zone_seen, err_seen;
    stamp_t      expected_q[$];
    int unsigned mismatches;

    function new();
      clear_fields();
      mismatches = 0;
    endfunction

    function void clear_fields();
      phase     = PH_DATE;
      date_cnt  = '0;
      year_f    = '0;
      month_f   = '0;
      day_f     = '0;
      hour_f    = '0;
      minute_f  = '0;
      second_f  = '0;
      zone_h    = '0;
      zone_m    = '0;
      zone_neg  = 1'b0;
      zone_seen = 1'b0;
      err_seen  = 1'b0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void zone_or_end(logic [7:0] c);
      if (c == CH_Z_UC || c == CH_Z_LC) begin
        zone_seen = 1'b1;
        phase     = PH_DONE;
      end else if (c == CH_PLUS || c == CH_DASH) begin
        zone_seen = 1'b1;
        zone_neg  = (c == CH_DASH);
        phase     = PH_OH1;
      end else begin
        phase = PH_DONE;
      end
    endfunction

    function void after_time(logic [7:0] c);
      if (c == CH_DOT) phase = PH_FRAC;
      else zone_or_end(c);
    endfunction

    function void advance(logic [7:0] c);
      logic       dig;
      logic [3:0] d;
      dig = (c >= CH_0) && (c <= CH_9);
      d   = 4'(c - CH_0);
      case (phase)
        PH_DATE: begin
          if (date_cnt == YEAR_END || date_cnt == MONTH_END) begin
            if (c != CH_DASH) err_seen = 1'b1;
          end else if (!dig) begin
            err_seen = 1'b1;
          end else if (date_cnt < YEAR_END) begin
            year_f = 14'(year_f * 10 + d);
          end else if (date_cnt < MONTH_END) begin
            month_f = 7'(month_f * 10 + d);
          end else begin
            day_f = 7'(day_f * 10 + d);
          end
          date_cnt = date_cnt + 4'd1;
          // count saturates: the date phase is left at ten characters
          if (date_cnt >= DATE_LEN) phase = PH_SEP;
        end
        PH_SEP: begin
          if (c == CH_T_UC || c == CH_T_LC || c == CH_SPACE) phase = PH_H1;
          else phase = PH_DONE;
        end
        PH_H1, PH_H2, PH_MI1, PH_MI2, PH_S1, PH_S2,
        PH_OH1, PH_OH2, PH_OM1, PH_OM2: begin
          // a required digit pair: anything else is malformed
          if (!dig) begin
            err_seen = 1'b1;
            phase    = PH_DONE;
          end else begin
            case (phase)
              PH_H1:   begin hour_f   = 7'(hour_f * 10 + d);   phase = PH_H2;     end
              PH_H2:   begin hour_f   = 7'(hour_f * 10 + d);   phase = PH_AFT_H;  end
              PH_MI1:  begin minute_f = 7'(minute_f * 10 + d); phase = PH_MI2;    end
              PH_MI2:  begin minute_f = 7'(minute_f * 10 + d); phase = PH_AFT_M;  end
              PH_S1:   begin second_f = 7'(second_f * 10 + d); phase = PH_S2;     end
              PH_S2:   begin second_f = 7'(second_f * 10 + d); phase = PH_AFT_S;  end
              PH_OH1:  begin zone_h   = 7'(zone_h * 10 + d);   phase = PH_OH2;    end
              PH_OH2:  begin zone_h   = 7'(zone_h * 10 + d);   phase = PH_AFT_OH; end
              PH_OM1:  begin zone_m   = 7'(zone_m * 10 + d);   phase = PH_OM2;    end
              default: begin zone_m   = 7'(zone_m * 10 + d);   phase = PH_DONE;   end
            endcase
          end
        end
        PH_AFT_H: begin
          if (c == CH_COLON) phase = PH_MI1;
          else after_time(c);
        end
        PH_AFT_M: begin
          if (c == CH_COLON) phase = PH_S1;
          else after_time(c);
        end
        PH_AFT_S: after_time(c);
        PH_FRAC: begin
          if (!dig) zone_or_end(c);
        end
        PH_AFT_OH: begin
          if (c == CH_COLON) begin
            phase = PH_OM1;
          end else if (dig) begin
            zone_m = 7'(d);
            phase  = PH_OMN;
          end else begin
            phase = PH_DONE;
          end
        end
        PH_OMN: begin
          // a lone minute digit followed by a non-digit counts as zero
          if (dig) zone_m = 7'(zone_m * 10 + d);
          else zone_m = '0;
          phase = PH_DONE;
        end
        default: ;
      endcase
    endfunction

    // Proleptic Gregorian days-from-civil with month and day roll-over.
    function logic signed [38:0] epoch_of_fields();
      longint yr, mon, mm, y, m, yp, era, yoe, doy, doe, days, secs, ofs, res;
      yr   = year_f;
      mon  = month_f;
      mm   = mon + 11;
      y    = yr - 1 + mm / 12;
      m    = mm % 12 + 1;
      if (m <= 2) y = y - 1;
      yp   = y + 400;
      era  = yp / 400;
      yoe  = yp - era * 400;
      doy  = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5;
      doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      days = era * 146097 - 146097 + doe - 719468 + longint'(day_f) - 1;
      secs = days * 86400 + longint'(hour_f) * 3600 + longint'(minute_f) * 60
           + longint'(second_f);
      ofs  = longint'(zone_h) * 3600 + longint'(zone_m) * 60;
      res  = zone_neg ? secs + ofs : secs - ofs;
      return res[38:0];
    endfunction

    // Run one accepted character; on the last one queue the predicted stamp.
    function void note_char(logic [7:0] c, logic fin);
      stamp_t s;
      logic   bad;
      advance(c);
      if (!fin) return;
      if (phase == PH_OMN) zone_m = '0;
      bad = err_seen || (date_cnt < DATE_LEN);
      case (phase)
        PH_H1, PH_H2, PH_MI1, PH_MI2, PH_S1, PH_S2,
        PH_OH1, PH_OH2, PH_OM1, PH_OM2: bad = 1'b1;
        default: ;
      endcase
      if (bad) begin
        s.status = 1'b1;
        s.epoch  = '0;
        s.zone   = 1'b0;
      end else begin
        s.status = 1'b0;
        s.epoch  = epoch_of_fields();
        s.zone   = zone_seen;
      end
      expected_q.push_back(s);
      clear_fields();
    endfunction

    function void check_stamp(logic st, logic signed [38:0] ep, logic zg);
      stamp_t s;
      if (expected_q.size() == 0) begin
        $error("result with no text pending: status=%0b epoch=%0d zone=%0b",
               st, ep, zg);
        mismatches++;
        return;
      end
      s = expected_q.pop_front();
      if (st !== s.status) begin
        $error("status: expected %0b, got %0b", s.status, st);
        mismatches++;
      end
      if (ep !== s.epoch) begin
        $error("epoch_seconds: expected %0d, got %0d", s.epoch, ep);
        mismatches++;
      end
      if (zg !== s.zone) begin
        $error("zone_given: expected %0b, got %0b", s.zone, zg);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [7:0]         char_code = '0;
  logic               last      = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               status;
  logic signed [38:0] epoch_seconds;
  logic               zone_given;

  timestamp_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned chars_sent = 0;
  int unsigned quiet_cycles = 0;
  bit          hold_off_req = 1'b0;
  bit          hold_off_done = 1'b0;
  logic [7:0]  text_q[$];

  iso8601_timestamp_parser DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .epoch_seconds(epoch_seconds),
    .zone_given   (zone_given)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Monitor both channels at the edge: values read here are the pre-edge ones,
  // so every handshake is seen exactly once. Also run the quiet-cycle watchdog.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid && in_ready) sb.note_char(char_code, last);
      if (out_valid && out_ready) sb.check_stamp(status, epoch_seconds, zone_given);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Receiver: stall at the current rate; on request hold ready low for a long
  // stretch so the parser backs up and stalls its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Offer one character; idle first at the current rate, then hold the
  // request until it is taken.
  task automatic send_char(input logic [7:0] c, input logic fin);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    last      <= fin;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic send_str(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text();
  endtask

  function automatic void put_digits(int unsigned v, int unsigned n);
    int unsigned div;
    div = 1;
    repeat (n - 1) div = div * 10;
    for (int i = 0; i < n; i++) begin
      text_q.push_back(CH_0 + 8'((v / div) % 10));
      div = div / 10;
    end
  endfunction

  // Mostly a plausible value, sometimes anything the digits can hold.
  function automatic int unsigned pick(int unsigned lo, int unsigned hi, int unsigned top);
    if ($urandom_range(9) < 6) return $urandom_range(hi, lo);
    return $urandom_range(top, 0);
  endfunction

  function automatic void build_well_formed();
    int unsigned z;
    text_q.delete();
    put_digits(pick(1900, 2100, 9999), 4);
    text_q.push_back(CH_DASH);
    put_digits(pick(1, 12, 99), 2);
    text_q.push_back(CH_DASH);
    put_digits(pick(1, 28, 99), 2);
    if ($urandom_range(9) < 8) begin
      case ($urandom_range(2))
        0:       text_q.push_back(CH_T_UC);
        1:       text_q.push_back(CH_T_LC);
        default: text_q.push_back(CH_SPACE);
      endcase
      put_digits(pick(0, 23, 99), 2);
      if ($urandom_range(3) != 0) begin
        text_q.push_back(CH_COLON);
        put_digits(pick(0, 59, 99), 2);
        if ($urandom_range(9) < 7) begin
          text_q.push_back(CH_COLON);
          put_digits(pick(0, 59, 99), 2);
        end
      end
      if ($urandom_range(9) < 3) begin
        text_q.push_back(CH_DOT);
        repeat ($urandom_range(4)) text_q.push_back(CH_0 + 8'($urandom_range(9)));
      end
      z = $urandom_range(5);
      if (z == 1) begin
        text_q.push_back(CH_Z_UC);
      end else if (z == 2) begin
        text_q.push_back(CH_Z_LC);
      end else if (z >= 3) begin
        text_q.push_back($urandom_range(1) ? CH_PLUS : CH_DASH);
        put_digits(pick(0, 14, 99), 2);
        case ($urandom_range(3))
          0: ;
          1: begin
            text_q.push_back(CH_COLON);
            put_digits(pick(0, 59, 99), 2);
          end
          2: put_digits(pick(0, 59, 99), 2);
          default: text_q.push_back(CH_0 + 8'($urandom_range(9)));
        endcase
      end
    end else if ($urandom_range(4) == 0) begin
      // a zone letter straight after the date is trailing text
      text_q.push_back(CH_Z_UC);
    end
    if ($urandom_range(99) < 15)
      repeat ($urandom_range(3, 1)) text_q.push_back(8'($urandom_range(126, 32)));
  endfunction

  function automatic void build_random_text();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(99);
    if (kind < 70) begin
      build_well_formed();
    end else if (kind < 90) begin
      // break a good text: corrupt one character or cut it short
      build_well_formed();
      if ($urandom_range(1)) begin
        text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
      end else begin
        n = $urandom_range(text_q.size(), 1);
        text_q = text_q[0:n-1];
      end
    end else begin
      text_q.delete();
      repeat ($urandom_range(16, 1)) text_q.push_back(8'($urandom_range(255)));
    end
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed texts: field extremes, every optional part and each corner
    send_str("1970-01-01");
    send_str("0000-00-00T00:00:00+99:99");
    send_str("9999-99-99T99:99:99-99:99");
    send_str("9999-12-31t23:59:59.999z");
    send_str("2024-02-29 12:34:56.78+05:30");
    send_str("2000-03-01T10:20:30-0730");
    send_str("2000-03-01T10:20+07");
    send_str("2000-03-01T10:20:30+073");
    send_str("2000-03-01T10:20:30-073x");
    send_str("2000-03-01T10.5Z");
    send_str("2000-03-01T10:20:30 tail");
    send_str("2000-03-01Z");
    send_str("2000-03-01X");
    // text ends inside a required digit pair
    send_str("2000-03-01T1");
    send_str("2000-03-01T10:");
    send_str("2000-03-01T10:20:3");
    send_str("2000-03-01T10:20:30+");
    send_str("2000-03-01T10:20:30+07:");
    send_str("2000-03-01T10:20:30+07:3");
    send_str("2000/03-01");
    send_str("200");
    // a digit with the top bit set is not a digit
    send_str("2000-01-01");
    text_q[6] = 8'hB1;
    send_text();

    // Random phases: free running, sender idling, receiver stalling, both light
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin send_idle_pct = 81; sink_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  sink_stall_pct = 81; end
        default: begin send_idle_pct = 8;  sink_stall_pct = 8;  end
      endcase
      if (p == 0) hold_off_req = 1'b1;
      for (int unsigned goal = chars_sent + PHASE_CHARS; chars_sent < goal; ) begin
        build_random_text();
        send_text();
      end
    end

    // Drain: drop the request, wait out the results, then a short tail
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/itp_pkg.sv
rtl/itp_ctrl.sv
rtl/itp_datapath.sv
rtl/iso8601_timestamp_parser.sv
rtl/itp_checker.sv
tb/tb_iso8601_timestamp_parser.sv
